@@ design/assert_macros.svh @@
// Assertion macros shared by the matcher RTL.
// Each macro expects clk_i and rst_ni in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define MMPBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be true at a clock edge out of reset
`define MMPBM_NEVER(lbl, cond, msg) \
  `MMPBM_ASSERT(lbl, !(cond), msg)

`endif

@@ design/mmpbm_pkg.sv @@
// Shared constants, codes and structs of the signature matcher.
// No dependencies; imported by mmpbm_if, mmpbm_window, mmpbm_check and the core.
package mmpbm_pkg;

  localparam int NumPatterns   = 16;
  localparam int MaxPatternLen = 64;
  localparam int PositionBits  = 24;
  localparam int GapLen        = 4;

  localparam int KindW      = 2;
  localparam int SlotFieldW = 4;
  localparam int BytePosW   = 6;
  localparam int ByteW      = 8;
  localparam int LenFieldW  = 7;
  localparam int GapOffW    = 6;
  localparam int HeaderW    = 16;
  localparam int StartW     = 24;

  localparam int SlotW = (NumPatterns > 1) ? $clog2(NumPatterns) : 1;
  localparam int IdxW  = $clog2(MaxPatternLen);
  localparam int LenW  = $clog2(MaxPatternLen + 1);
  localparam int RowW  = MaxPatternLen * ByteW;
  localparam int ScanW = $clog2(NumPatterns + 1);
  localparam int CmpW  = (PositionBits > HeaderW) ? PositionBits : HeaderW;

  typedef enum logic [KindW-1:0] {
    KindLoadByte = 2'd0,
    KindSetDesc  = 2'd1,
    KindImage    = 2'd2,
    KindRestart  = 2'd3
  } kind_e;

  typedef struct packed {
    logic             shift;
    logic             clear;
    logic [ByteW-1:0] data;
  } win_ctrl_t;

  typedef struct packed {
    logic                    valid;
    logic [SlotW-1:0]        slot;
    logic [LenW-1:0]         len;
    logic                    has_gap;
    logic [GapOffW-1:0]      gap_off;
    logic                    ok;
    logic [PositionBits-1:0] start;
  } probe_t;

  typedef struct packed {
    logic                    hit;
    logic [SlotW-1:0]        slot;
    logic [PositionBits-1:0] start;
  } hit_t;

endpackage

@@ design/mmpbm_if.sv @@
// Valid/ready channel interfaces for input items and match results.
// Depends on mmpbm_pkg for field widths.
interface mmpbm_in_if import mmpbm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [KindW-1:0]      kind;
  logic [SlotFieldW-1:0] pattern_slot;
  logic [BytePosW-1:0]   byte_position;
  logic [ByteW-1:0]      byte_value;
  logic [LenFieldW-1:0]  pattern_length;
  logic                  has_gap;
  logic [GapOffW-1:0]    gap_offset;

  modport source (output valid, kind, pattern_slot, byte_position, byte_value,
                  pattern_length, has_gap, gap_offset, input ready);
  modport sink (input valid, kind, pattern_slot, byte_position, byte_value,
                pattern_length, has_gap, gap_offset, output ready);
endinterface

interface mmpbm_out_if import mmpbm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  matched;
  logic [SlotFieldW-1:0] match_slot;
  logic [StartW-1:0]     start_offset;
  logic                  last;

  modport source (output valid, matched, match_slot, start_offset, last, input ready);
  modport sink (input valid, matched, match_slot, start_offset, last, output ready);
endinterface

@@ design/mmpbm_ram.sv @@
// Generic single-clock RAM, one write port and one registered read port.
// No package dependencies.
module mmpbm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/mmpbm_window.sv @@
// Image byte window with fill count and the aligning byte shifter.
// Depends on mmpbm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mmpbm_window import mmpbm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  win_ctrl_t       ctrl_i,
  input  logic [LenW-1:0] len_i,
  output logic [RowW-1:0] aligned_o,
  output logic [LenW-1:0] fill_o
);

  logic [MaxPatternLen-1:0][ByteW-1:0] win_q;
  logic [LenW-1:0]                     fill_q;
  logic [RowW-1:0]                     rev;
  logic [LenW-1:0]                     amt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      fill_q <= '0;
    end else if (ctrl_i.clear) begin
      win_q  <= '0;
      fill_q <= '0;
    end else if (ctrl_i.shift) begin
      win_q <= {win_q[MaxPatternLen-2:0], ctrl_i.data};
      if (fill_q != LenW'(MaxPatternLen)) begin
        fill_q <= fill_q + LenW'(1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MaxPatternLen; i++) begin
      rev[i*ByteW +: ByteW] = win_q[MaxPatternLen-1-i];
    end
  end

  assign amt       = LenW'(MaxPatternLen) - len_i;
  assign aligned_o = rev >> (amt * ByteW);
  assign fill_o    = fill_q;

  `MMPBM_NEVER(a_fill_bound, fill_q > LenW'(MaxPatternLen), "window fill past depth")

endmodule

@@ design/mmpbm_check.sv @@
// Compare stage: registers the aligned window and byte mask of one slot,
// then checks them against the signature row. Depends on mmpbm_pkg.
module mmpbm_check import mmpbm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  probe_t          probe_i,
  input  logic [RowW-1:0] aligned_i,
  input  logic [RowW-1:0] sig_i,
  output hit_t            hit_o
);

  logic                     valid_q;
  logic                     ok_q;
  logic [SlotW-1:0]         slot_q;
  logic [PositionBits-1:0]  start_q;
  logic [MaxPatternLen-1:0] mask_d, mask_q;
  logic [RowW-1:0]          win_q;
  logic [MaxPatternLen-1:0] eq;

  always_comb begin
    for (int p = 0; p < MaxPatternLen; p++) begin
      mask_d[p] = (p < int'(probe_i.len)) &&
                  !(probe_i.has_gap && p >= int'(probe_i.gap_off) &&
                    p < int'(probe_i.gap_off) + GapLen);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= probe_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (probe_i.valid) begin
      ok_q    <= probe_i.ok;
      slot_q  <= probe_i.slot;
      start_q <= probe_i.start;
      mask_q  <= mask_d;
      win_q   <= aligned_i;
    end
  end

  always_comb begin
    for (int p = 0; p < MaxPatternLen; p++) begin
      eq[p] = (sig_i[p*ByteW +: ByteW] == win_q[p*ByteW +: ByteW]) || !mask_q[p];
    end
  end

  assign hit_o.hit   = valid_q && ok_q && (&eq);
  assign hit_o.slot  = slot_q;
  assign hit_o.start = start_q;

endmodule

@@ design/masked_multi_pattern_byte_matcher_core.sv @@
// Masked multi-pattern byte matcher: top level with sequencer, descriptor
// table and result register. Depends on mmpbm_pkg, mmpbm_if, mmpbm_ram,
// mmpbm_window, mmpbm_check and assert_macros.svh.
//
// Usage: items enter on in_i (valid/ready); results leave on out_o, one word
// per match, the final word of each item flagged by last. An item with no
// match gives one word with matched low. The user must write header_bytes
// through cfg_we_i/cfg_wdata_i while the block is idle (not enforced).
// Timing: in_i.ready is high only while the sequencer idles. A signature
// byte load steps through accept, row read, row write and result; a
// descriptor write or restart through accept and result. An image byte
// sweeps the table one slot per cycle through the shared compare stage,
// then emits its result words; the table sweep and the one read port of
// the signature RAM set the duration of the sweep.
// Reset clears the window, descriptors, position and header length; the
// signature RAM is not cleared. A stalled out_o holds its word; the
// sequencer waits on the result register before loading another word.
`include "assert_macros.svh"

module masked_multi_pattern_byte_matcher_core import mmpbm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [HeaderW-1:0] cfg_wdata_i,
  mmpbm_in_if.sink           in_i,
  mmpbm_out_if.source        out_o
);

  typedef enum logic [2:0] {
    StIdle,
    StLoadRd,
    StLoadWr,
    StScan,
    StEmit
  } state_e;

  state_e                  state_q;
  logic [HeaderW-1:0]      header_q;
  logic [PositionBits-1:0] pos_q;
  logic [ScanW-1:0]        cnt_q;
  logic [SlotW-1:0]        slot_q;
  logic [IdxW-1:0]         bpos_q;
  logic [ByteW-1:0]        bval_q;
  logic                    load_ok_q;

  logic [LenW-1:0]    len_q  [NumPatterns];
  logic               gap_q  [NumPatterns];
  logic [GapOffW-1:0] goff_q [NumPatterns];

  logic [NumPatterns-1:0]  hits_q;
  logic [PositionBits-1:0] starts_q [NumPatterns];

  logic                  out_valid_q;
  logic                  out_matched_q;
  logic [SlotFieldW-1:0] out_slot_q;
  logic [StartW-1:0]     out_start_q;
  logic                  out_last_q;

  kind_e                   kind;
  logic                    in_fire;
  logic                    out_free;
  logic                    scan_issue;
  logic                    emit_take;
  logic [SlotW-1:0]        scan_slot;
  logic [LenW-1:0]         len_sel;
  logic [PositionBits-1:0] start_calc;
  logic [LenW-1:0]         fill;
  logic [RowW-1:0]         aligned;
  logic [RowW-1:0]         rdata;
  logic [RowW-1:0]         wdata;
  logic                    ram_re;
  logic [SlotW-1:0]        ram_raddr;
  logic [NumPatterns-1:0]  low;
  logic [NumPatterns-1:0]  rest;
  logic [SlotW-1:0]        sel;
  win_ctrl_t               win_ctrl;
  probe_t                  probe;
  hit_t                    chk_hit;

  assign kind       = kind_e'(in_i.kind);
  assign in_i.ready = (state_q == StIdle);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign win_ctrl.shift = in_fire && (kind == KindImage);
  assign win_ctrl.clear = in_fire && (kind == KindRestart);
  assign win_ctrl.data  = in_i.byte_value;

  assign scan_issue = (state_q == StScan) && (cnt_q < ScanW'(NumPatterns));
  assign scan_slot  = scan_issue ? cnt_q[SlotW-1:0] : '0;
  assign len_sel    = len_q[scan_slot];
  assign start_calc = pos_q + PositionBits'(1) - PositionBits'(len_sel);

  assign probe.valid   = scan_issue;
  assign probe.slot    = scan_slot;
  assign probe.len     = len_sel;
  assign probe.has_gap = gap_q[scan_slot];
  assign probe.gap_off = goff_q[scan_slot];
  assign probe.start   = start_calc;
  assign probe.ok      = (len_sel != '0) && (len_sel <= fill) &&
                         (CmpW'(start_calc) >= CmpW'(header_q));

  assign ram_re    = (state_q == StLoadRd) || scan_issue;
  assign ram_raddr = (state_q == StLoadRd) ? slot_q : scan_slot;

  always_comb begin
    for (int p = 0; p < MaxPatternLen; p++) begin
      wdata[p*ByteW +: ByteW] = (bpos_q == IdxW'(p)) ? bval_q : rdata[p*ByteW +: ByteW];
    end
  end

  assign low  = hits_q & (~hits_q + NumPatterns'(1));
  assign rest = hits_q & ~low;

  always_comb begin
    sel = '0;
    for (int s = NumPatterns - 1; s >= 0; s--) begin
      if (hits_q[s]) begin
        sel = SlotW'(s);
      end
    end
  end

  assign emit_take = (state_q == StEmit) && out_free && (hits_q != '0);

  mmpbm_ram #(
    .Width (RowW),
    .Depth (NumPatterns)
  ) u_sig_ram (
    .clk_i   (clk_i),
    .we_i    ((state_q == StLoadWr) && load_ok_q),
    .waddr_i (slot_q),
    .wdata_i (wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  mmpbm_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (win_ctrl),
    .len_i     (len_sel),
    .aligned_o (aligned),
    .fill_o    (fill)
  );

  mmpbm_check u_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .probe_i   (probe),
    .aligned_i (aligned),
    .sig_i     (rdata),
    .hit_o     (chk_hit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= '0;
    end else if (cfg_we_i) begin
      header_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NumPatterns; s++) begin
        len_q[s]  <= '0;
        gap_q[s]  <= 1'b0;
        goff_q[s] <= '0;
      end
    end else if (in_fire && (kind == KindSetDesc) &&
                 (int'(in_i.pattern_slot) < NumPatterns)) begin
      len_q[SlotW'(in_i.pattern_slot)] <= (int'(in_i.pattern_length) > MaxPatternLen) ?
                                          LenW'(MaxPatternLen) :
                                          LenW'(in_i.pattern_length);
      gap_q[SlotW'(in_i.pattern_slot)]  <= in_i.has_gap;
      goff_q[SlotW'(in_i.pattern_slot)] <= in_i.gap_offset;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q <= '0;
    end else if (in_fire) begin
      hits_q <= '0;
    end else if (chk_hit.hit) begin
      hits_q[chk_hit.slot] <= 1'b1;
    end else if (emit_take) begin
      hits_q <= rest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (chk_hit.hit) begin
      starts_q[chk_hit.slot] <= chk_hit.start;
    end
    if (in_fire) begin
      slot_q    <= SlotW'(in_i.pattern_slot);
      bpos_q    <= IdxW'(in_i.byte_position);
      bval_q    <= in_i.byte_value;
      load_ok_q <= (int'(in_i.pattern_slot) < NumPatterns) &&
                   (int'(in_i.byte_position) < MaxPatternLen);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      pos_q         <= '0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
      out_matched_q <= 1'b0;
      out_slot_q    <= '0;
      out_start_q   <= '0;
      out_last_q    <= 1'b0;
    end else begin
      if ((state_q == StEmit) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            unique case (kind)
              KindLoadByte: state_q <= StLoadRd;
              KindSetDesc:  state_q <= StEmit;
              KindImage: begin
                cnt_q   <= '0;
                state_q <= StScan;
              end
              KindRestart: begin
                pos_q   <= '0;
                state_q <= StEmit;
              end
              default: state_q <= StEmit;
            endcase
          end
        end
        StLoadRd: state_q <= StLoadWr;
        StLoadWr: state_q <= StEmit;
        StScan: begin
          if (cnt_q == ScanW'(NumPatterns)) begin
            pos_q   <= pos_q + PositionBits'(1);
            state_q <= StEmit;
          end else begin
            cnt_q <= cnt_q + ScanW'(1);
          end
        end
        StEmit: begin
          if (out_free) begin
            if (hits_q == '0) begin
              out_matched_q <= 1'b0;
              out_slot_q    <= '0;
              out_start_q   <= '0;
              out_last_q    <= 1'b1;
              state_q       <= StIdle;
            end else begin
              out_matched_q <= 1'b1;
              out_slot_q    <= SlotFieldW'(sel);
              out_start_q   <= StartW'(starts_q[sel]);
              out_last_q    <= (rest == '0);
              if (rest == '0) begin
                state_q <= StIdle;
              end
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.matched      = out_matched_q;
  assign out_o.match_slot   = out_slot_q;
  assign out_o.start_offset = out_start_q;
  assign out_o.last         = out_last_q;

  `MMPBM_ASSERT(a_more_words_pending, out_o.valid && !out_o.last |-> state_q == StEmit, "non-final word without emit pending")
  `MMPBM_ASSERT(a_nomatch_word, out_o.valid && !out_o.matched |-> out_o.last && out_o.start_offset == '0, "no-match word malformed")
  `MMPBM_ASSERT(a_scan_bound, state_q == StScan |-> cnt_q <= ScanW'(NumPatterns), "scan counter past table")
  `MMPBM_ASSERT(a_pos_idle, state_q == StIdle && !in_fire |=> $stable(pos_q), "position moved without an item")

endmodule

@@ sim/masked_multi_pattern_byte_matcher_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the masked multi-pattern byte matcher core: a directed table,
// then random phases, every result word checked against a behavioral predictor.
// Depends on mmpbm_pkg, mmpbm_if and masked_multi_pattern_byte_matcher_core.
module masked_multi_pattern_byte_matcher_core_tb;
  import mmpbm_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int RandItems  = 250;
  localparam int HoldCycles = 400;

  typedef struct packed {
    kind_e                 kind;
    logic [SlotFieldW-1:0] pattern_slot;
    logic [BytePosW-1:0]   byte_position;
    logic [ByteW-1:0]      byte_value;
    logic [LenFieldW-1:0]  pattern_length;
    logic                  has_gap;
    logic [GapOffW-1:0]    gap_offset;
  } sig_item_t;

  typedef struct packed {
    logic                  matched;
    logic [SlotFieldW-1:0] match_slot;
    logic [StartW-1:0]     start_offset;
    logic                  last;
  } match_word_t;

  typedef struct packed {
    sig_item_t item;
    logic      fixed;
  } dir_row_t;

  localparam match_word_t NoMatch = '{matched: 1'b0, match_slot: '0, start_offset: '0,
                                      last: 1'b1};

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [HeaderW-1:0] cfg_wdata;

  mmpbm_in_if  in_if ();
  mmpbm_out_if out_if ();

  masked_multi_pattern_byte_matcher_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  bit [ByteW-1:0]         recent_bytes [MaxPatternLen];
  bit [ByteW-1:0]         sig_bytes [NumPatterns][MaxPatternLen];
  bit [MaxPatternLen-1:0] sig_written [NumPatterns];
  int unsigned            sig_len [NumPatterns];
  bit                     gap_en [NumPatterns];
  int unsigned            gap_at [NumPatterns];
  bit [PositionBits-1:0]  img_pos;
  int unsigned            bytes_seen;
  bit [HeaderW-1:0]       header_len;

  match_word_t awaited_words [$];
  match_word_t fresh_words [$];

  int  mismatches = 0;
  int  cycles     = 0;
  int  items_sent = 0;
  int  sink_hold  = 0;
  bit  src_fast   = 1'b0;
  bit  snk_fast   = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("[masked_multi_pattern_byte_matcher_core] ERROR");
      $finish;
    end
  end

  function automatic bit gap_byte(input int s, input int p);
    return gap_en[s] && p >= gap_at[s] && p < gap_at[s] + GapLen;
  endfunction

  function automatic bit slot_hit(input int s);
    int unsigned n;
    n = sig_len[s];
    if (n == 0 || n > bytes_seen) return 1'b0;
    for (int p = 0; p < n; p++) begin
      if (gap_byte(s, p)) continue;
      if (sig_bytes[s][p] != recent_bytes[n - 1 - p]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic predict_matches(input sig_item_t it);
    match_word_t          w;
    logic [StartW-1:0]    st;
    int                   s;
    fresh_words.delete();
    case (it.kind)
      KindLoadByte: begin
        sig_bytes[it.pattern_slot][it.byte_position] = it.byte_value;
        sig_written[it.pattern_slot][it.byte_position] = 1'b1;
      end
      KindSetDesc: begin
        sig_len[it.pattern_slot] = (it.pattern_length > MaxPatternLen) ? MaxPatternLen :
                                   int'(it.pattern_length);
        gap_en[it.pattern_slot] = it.has_gap;
        gap_at[it.pattern_slot] = int'(it.gap_offset);
      end
      KindImage: begin
        for (int i = MaxPatternLen - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i - 1];
        recent_bytes[0] = it.byte_value;
        if (bytes_seen < MaxPatternLen) bytes_seen++;
        for (s = 0; s < NumPatterns && fresh_words.size() < 16; s++) begin
          if (slot_hit(s)) begin
            st = img_pos + 1'b1 - StartW'(sig_len[s]);
            if (st >= StartW'(header_len)) begin
              w.matched      = 1'b1;
              w.match_slot   = SlotFieldW'(s);
              w.start_offset = st;
              w.last         = 1'b0;
              fresh_words.insert(fresh_words.size(), w);
            end
          end
        end
        img_pos = img_pos + 1'b1;
      end
      default: begin
        for (int i = 0; i < MaxPatternLen; i++) recent_bytes[i] = '0;
        bytes_seen = 0;
        img_pos    = '0;
      end
    endcase
    if (fresh_words.size() == 0) fresh_words.insert(0, NoMatch);
    else fresh_words[fresh_words.size() - 1].last = 1'b1;
  endtask

  task automatic report_mismatch(input string what, input match_word_t got,
                                 input match_word_t want);
    mismatches++;
    if (mismatches <= 50)
      $display("%0t mismatch (%s): got m=%0b slot=%0d start=%0d last=%0b,",
               $time, what, got.matched, got.match_slot, got.start_offset, got.last,
               " want m=%0b slot=%0d start=%0d last=%0b",
               want.matched, want.match_slot, want.start_offset, want.last);
  endtask

  // hold the item until accepted, then queue what it should produce
  task automatic send_item(input sig_item_t it, input bit typed);
    int gap;
    gap = src_fast ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.kind           <= it.kind;
    in_if.pattern_slot   <= it.pattern_slot;
    in_if.byte_position  <= it.byte_position;
    in_if.byte_value     <= it.byte_value;
    in_if.pattern_length <= it.pattern_length;
    in_if.has_gap        <= it.has_gap;
    in_if.gap_offset     <= it.gap_offset;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    items_sent++;
    predict_matches(it);
    if (typed) begin
      awaited_words.insert(awaited_words.size(), NoMatch);
    end else begin
      foreach (fresh_words[k]) begin
        awaited_words.insert(awaited_words.size(), fresh_words[k]);
      end
    end
  endtask

  function automatic sig_item_t make_item(input kind_e k);
    sig_item_t it;
    it.kind           = k;
    it.pattern_slot   = SlotFieldW'($urandom);
    it.byte_position  = BytePosW'($urandom);
    it.byte_value     = ByteW'($urandom);
    it.pattern_length = LenFieldW'($urandom);
    it.has_gap        = 1'($urandom);
    it.gap_offset     = GapOffW'($urandom);
    return it;
  endfunction

  function automatic dir_row_t row(input kind_e k, input int s, input int p, input int v,
                                   input int n, input bit g, input int go, input bit fixed);
    dir_row_t r;
    r.item.kind           = k;
    r.item.pattern_slot   = SlotFieldW'(s);
    r.item.byte_position  = BytePosW'(p);
    r.item.byte_value     = ByteW'(v);
    r.item.pattern_length = LenFieldW'(n);
    r.item.has_gap        = g;
    r.item.gap_offset     = GapOffW'(go);
    r.fixed               = fixed;
    return r;
  endfunction

  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(0, 4))
      0: return 8'h41;
      1: return 8'h42;
      2: return 8'h00;
      3: return 8'hC3;
      default: return ByteW'($urandom);
    endcase
  endfunction

  task automatic send_image(input logic [ByteW-1:0] v);
    sig_item_t it;
    it = make_item(KindImage);
    it.byte_value = v;
    send_item(it, 1'b0);
  endtask

  task automatic send_load(input int s, input int p, input logic [ByteW-1:0] v);
    sig_item_t it;
    it = make_item(KindLoadByte);
    it.pattern_slot  = SlotFieldW'(s);
    it.byte_position = BytePosW'(p);
    it.byte_value    = v;
    send_item(it, 1'b0);
  endtask

  task automatic send_desc(input int s, input int n, input bit g, input int go);
    sig_item_t it;
    it = make_item(KindSetDesc);
    it.pattern_slot   = SlotFieldW'(s);
    it.pattern_length = LenFieldW'(n);
    it.has_gap        = g;
    it.gap_offset     = GapOffW'(go);
    send_item(it, 1'b0);
  endtask

  // drop valid and wait out every pending word
  task automatic settle();
    in_if.valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_header(input logic [HeaderW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    header_len = v;
  endtask

  initial begin : result_side
    match_word_t got;
    match_word_t want;
    string       fields;
    int          gap;
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (sink_hold > 0) begin
        out_if.ready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end
      gap = snk_fast ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      got.matched      = out_if.matched;
      got.match_slot   = out_if.match_slot;
      got.start_offset = out_if.start_offset;
      got.last         = out_if.last;
      if (awaited_words.size() == 0) begin
        report_mismatch("no word pending", got, NoMatch);
      end else begin
        want   = awaited_words.pop_front();
        fields = "";
        if (got.matched !== want.matched) fields = {fields, " matched"};
        if (got.match_slot !== want.match_slot) fields = {fields, " match_slot"};
        if (got.start_offset !== want.start_offset) fields = {fields, " start_offset"};
        if (got.last !== want.last) fields = {fields, " last"};
        if (fields != "") report_mismatch({"field", fields}, got, want);
      end
    end
  end

  initial begin : stimulus
    dir_row_t         dir_rows [$];
    logic [ByteW-1:0] v;
    int               phase, s, k, nprog, lenf, eff, cut, sel, tries, goff, n, long_slot;
    bit               g;

    in_if.valid          <= 1'b0;
    in_if.kind           <= KindLoadByte;
    in_if.pattern_slot   <= '0;
    in_if.byte_position  <= '0;
    in_if.byte_value     <= '0;
    in_if.pattern_length <= '0;
    in_if.has_gap        <= 1'b0;
    in_if.gap_offset     <= '0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    rst_n                <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_rows = '{
      row(KindImage,    0,  0, 8'h00, 0, 1'b0, 0,  1'b1),
      row(KindRestart,  0,  0, 8'h00, 0, 1'b0, 0,  1'b1),
      row(KindLoadByte, 0,  0, 8'hA5, 0, 1'b0, 0,  1'b1),
      row(KindLoadByte, 0,  1, 8'h5A, 0, 1'b0, 0,  1'b1),
      row(KindLoadByte, 15, 63, 8'hFF, 127, 1'b1, 63, 1'b1),
      row(KindLoadByte, 15, 0, 8'h00, 0, 1'b0, 0,  1'b1),
      row(KindSetDesc,  0,  0, 8'h00, 2, 1'b0, 0,  1'b1),
      row(KindImage,    0,  0, 8'hA5, 0, 1'b0, 0,  1'b0),
      row(KindImage,    0,  0, 8'h5A, 0, 1'b0, 0,  1'b0),
      row(KindImage,    0,  0, 8'h5A, 0, 1'b0, 0,  1'b0),
      row(KindRestart,  0,  0, 8'h00, 0, 1'b0, 0,  1'b1),
      row(KindImage,    0,  0, 8'h5A, 0, 1'b0, 0,  1'b0),
      row(KindLoadByte, 1,  0, 8'h5A, 0, 1'b0, 0,  1'b1),
      row(KindLoadByte, 1,  1, 8'h11, 0, 1'b0, 0,  1'b1),
      row(KindLoadByte, 1,  2, 8'h22, 0, 1'b0, 0,  1'b1),
      row(KindSetDesc,  1,  0, 8'h00, 3, 1'b1, 1,  1'b1),
      row(KindImage,    0,  0, 8'h33, 0, 1'b0, 0,  1'b0),
      row(KindImage,    0,  0, 8'h44, 0, 1'b0, 0,  1'b0),
      row(KindSetDesc,  2,  0, 8'h00, 0, 1'b1, 63, 1'b1),
      row(KindImage,    0,  0, 8'hFF, 0, 1'b0, 0,  1'b0)
    };
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].fixed);

    // every slot hits on one byte
    settle();
    for (s = 0; s < NumPatterns; s++) begin
      send_load(s, 0, 8'h77);
      send_desc(s, 1, 1'b0, 0);
    end
    repeat (2) send_image(8'h77);

    phase     = 0;
    long_slot = 0;
    while ((items_sent < RandItems || phase < 4) && phase < 64) begin
      settle();
      if (phase == 0) write_header(16'hFFFF);
      else if (phase == 1 || $urandom_range(0, 2) == 0) write_header('0);
      else write_header(HeaderW'($urandom_range(1, 40)));
      src_fast = ($urandom_range(0, 3) == 0);
      snk_fast = ($urandom_range(0, 3) == 0);

      if (phase == 2) send_desc(long_slot, 127, 1'b1, $urandom_range(0, 63));
      nprog = $urandom_range(1, 3);
      for (k = 0; k < nprog; k++) begin
        s = $urandom_range(0, NumPatterns - 1);
        if (phase == 1 && k == 0) begin
          lenf      = MaxPatternLen;
          long_slot = s;
        end else if ($urandom_range(0, 9) == 0) begin
          lenf = 0;
        end else begin
          lenf = $urandom_range(1, 10);
        end
        eff = (lenf > MaxPatternLen) ? MaxPatternLen : lenf;
        for (int p = 0; p < eff; p++) send_load(s, p, pick_byte());
        g    = ($urandom_range(0, 2) == 0);
        goff = (g && $urandom_range(0, 3) != 0) ? $urandom_range(0, eff) : $urandom_range(0, 63);
        send_desc(s, lenf, g, goff);
      end

      if (phase == 3) sink_hold = HoldCycles;

      repeat ($urandom_range(5, 9)) begin
        sel   = $urandom_range(0, 99);
        s     = $urandom_range(0, NumPatterns - 1);
        tries = 0;
        while (sig_len[s] == 0 && tries < NumPatterns) begin
          s = (s + 1) % NumPatterns;
          tries++;
        end
        if (sel < 78 && sig_len[s] != 0) begin
          repeat ($urandom_range(0, 3)) send_image(pick_byte());
          cut = (sel < 64) ? sig_len[s] : $urandom_range(0, sig_len[s]);
          for (int p = 0; p < cut; p++) begin
            v = gap_byte(s, p) ? ByteW'($urandom) : sig_bytes[s][p];
            if (sel >= 64 && sel < 70 && p == cut - 1) v = ~v;
            send_image(v);
          end
        end else if (sel < 86) begin
          send_item(make_item(KindRestart), 1'b0);
        end else if (sel < 91) begin
          send_load(s, $urandom_range(0, MaxPatternLen - 1), ByteW'($urandom));
        end else if (sel < 96) begin
          n = 0;
          while (n < MaxPatternLen && sig_written[s][n]) n++;
          lenf = (n == MaxPatternLen) ? $urandom_range(MaxPatternLen, 127) : $urandom_range(0, n);
          send_desc(s, lenf, 1'($urandom_range(0, 1)), $urandom_range(0, 63));
        end else begin
          send_image(ByteW'($urandom));
        end
      end
      phase++;
    end

    settle();
    repeat (32) @(posedge clk);
    if (mismatches == 0) begin
      $display("[masked_multi_pattern_byte_matcher_core] OK");
    end else begin
      $display("[masked_multi_pattern_byte_matcher_core] ERROR");
    end
    $finish;
  end

endmodule

@@ masked_multi_pattern_byte_matcher_core.f @@
+incdir+design
design/mmpbm_pkg.sv
design/mmpbm_if.sv
design/mmpbm_ram.sv
design/mmpbm_window.sv
design/mmpbm_check.sv
design/masked_multi_pattern_byte_matcher_core.sv
sim/masked_multi_pattern_byte_matcher_core_tb.sv
